[hw/rtl/bmsi_pkg.sv]
// Shared types and constants for the bank mapper with scanline IRQ.
// Used by bmsi_decode and bank_mapper_scanline_irq.
`default_nettype none

package bmsi_pkg;

    typedef enum logic [1:0] {
        ACT_READ  = 2'd0,
        ACT_WRITE = 2'd1,
        ACT_TICK  = 2'd2
    } t_action;

    typedef enum logic [1:0] {
        VAR_NORMAL = 2'd0,
        VAR_INC    = 2'd1,
        VAR_RAM    = 2'd2,
        VAR_NO_NT  = 2'd3
    } t_variant;

    // configuration register indexes
    localparam logic CFG_VARIANT  = 1'b0;
    localparam logic CFG_IRQ_STEP = 1'b1;

    localparam logic [7:0]  IRQ_STEP_RST = 8'd113;
    localparam logic [14:0] COUNT_TOP    = 15'h7FFF;
    localparam logic [7:0]  VRAM_MIN     = 8'hE0;
    localparam logic [15:0] RAM_PORT     = 16'h4800;
    localparam logic [15:0] PTR_PORT     = 16'hF800;

    // 2K regions, address bits 15:11
    localparam logic [4:0] RGN_CNT_LO = 5'h0A;  // 0x5000
    localparam logic [4:0] RGN_CNT_HI = 5'h0B;  // 0x5800
    localparam logic [4:0] RGN_PRG0   = 5'h1C;  // 0xE000
    localparam logic [4:0] RGN_PRG1   = 5'h1D;  // 0xE800
    localparam logic [4:0] RGN_PRG2   = 5'h1E;  // 0xF000

    localparam logic [3:0] SLOT_NT0  = 4'd8;
    localparam logic [3:0] SLOT_PRG0 = 4'd12;
    localparam logic [3:0] SLOT_PRG1 = 4'd13;
    localparam logic [3:0] SLOT_PRG2 = 4'd14;

    localparam int RAM_DEPTH = 128;
    localparam int RAM_AW    = 7;

    typedef struct packed {
        logic [1:0]  action;
        logic [15:0] address;
        logic [7:0]  data;
    } t_item;

    typedef struct packed {
        logic [14:0] irq_count;
        logic        irq_on;
        logic        lo_sel;
        logic        hi_sel;
        logic [7:0]  ram_ptr;
    } t_state;

    typedef struct packed {
        logic [7:0] read_data;
        logic       irq_pulse;
        logic       map_valid;
        logic [3:0] map_slot;
        logic       map_is_vram;
        logic [7:0] map_bank;
        logic       sound_access;
    } t_result;

    typedef struct packed {
        logic              rd;
        logic              wr;
        logic [RAM_AW-1:0] idx;
    } t_ram_ctl;

endpackage

`default_nettype wire

[hw/rtl/bmsi_decode.sv]
// Combinational decode of one bus beat or scanline tick: next mapper state,
// result fields and side RAM control. Depends on bmsi_pkg.
`default_nettype none

module bmsi_decode (
    input  wire bmsi_pkg::t_item    i_item,
    input  wire bmsi_pkg::t_state   i_state,
    input  wire bmsi_pkg::t_variant i_variant,
    input  wire logic [7:0]         i_irq_step,
    output bmsi_pkg::t_state        o_state,
    output bmsi_pkg::t_result       o_result,
    output bmsi_pkg::t_ram_ctl      o_ram
);

    logic [4:0]  region;
    logic        ram_mode;
    logic [15:0] tick_sum;
    logic [14:0] hi_count;
    logic [7:0]  ptr_adv;
    logic        pat_sel;

    assign region   = i_item.address[15:11];
    assign ram_mode = (i_variant == bmsi_pkg::VAR_RAM);
    assign tick_sum = {1'b0, i_state.irq_count} + {8'd0, i_irq_step};
    assign hi_count = {i_item.data[6:0], i_state.irq_count[7:0]};
    assign ptr_adv  = i_state.ram_ptr[7] ? {1'b1, i_state.ram_ptr[6:0] + 7'd1}
                                         : i_state.ram_ptr;
    assign pat_sel  = i_item.address[13] ? i_state.hi_sel : i_state.lo_sel;

    always_comb begin
        o_state  = i_state;
        o_result = '0;
        o_ram.rd  = 1'b0;
        o_ram.wr  = 1'b0;
        o_ram.idx = i_state.ram_ptr[6:0];

        unique case (i_item.action)
            bmsi_pkg::ACT_READ: begin
                if (i_item.address == bmsi_pkg::RAM_PORT) begin
                    if (ram_mode) begin
                        o_ram.rd        = 1'b1;
                        o_state.ram_ptr = ptr_adv;
                    end else begin
                        o_result.sound_access = 1'b1;
                    end
                end else if (region == bmsi_pkg::RGN_CNT_LO) begin
                    o_result.read_data = i_state.irq_count[7:0];
                end else if (region == bmsi_pkg::RGN_CNT_HI) begin
                    o_result.read_data = {1'b0, i_state.irq_count[14:8]};
                end else begin
                    o_result.read_data = i_item.address[15:8];
                end
            end
            bmsi_pkg::ACT_WRITE: begin
                if (i_item.address == bmsi_pkg::RAM_PORT) begin
                    if (ram_mode) begin
                        o_ram.wr        = 1'b1;
                        o_state.ram_ptr = ptr_adv;
                    end else begin
                        o_result.sound_access = 1'b1;
                    end
                end else if (region == bmsi_pkg::RGN_CNT_LO) begin
                    o_state.irq_count = {i_state.irq_count[14:8], i_item.data};
                end else if (region == bmsi_pkg::RGN_CNT_HI) begin
                    o_state.irq_on = i_item.data[7];
                    if ((i_variant == bmsi_pkg::VAR_INC || ram_mode) &&
                        hi_count != bmsi_pkg::COUNT_TOP) begin
                        o_state.irq_count = hi_count + 15'd1;
                    end else begin
                        o_state.irq_count = hi_count;
                    end
                end else if (i_item.address[15:14] == 2'b10) begin
                    // pattern slots 0-7
                    o_result.map_valid = 1'b1;
                    o_result.map_slot  = {1'b0, i_item.address[13:11]};
                    if (i_item.data < bmsi_pkg::VRAM_MIN || pat_sel) begin
                        o_result.map_bank = i_item.data;
                    end else begin
                        o_result.map_is_vram = 1'b1;
                        o_result.map_bank    = {7'd0, i_item.data[0]};
                    end
                end else if (i_item.address[15:13] == 3'b110) begin
                    // nametable slots 8-11
                    if (i_variant != bmsi_pkg::VAR_NO_NT) begin
                        o_result.map_valid = 1'b1;
                        o_result.map_slot  = bmsi_pkg::SLOT_NT0 +
                                             {2'b00, i_item.address[12:11]};
                        if (i_item.data < bmsi_pkg::VRAM_MIN) begin
                            o_result.map_bank = i_item.data;
                        end else begin
                            o_result.map_is_vram = 1'b1;
                            o_result.map_bank    = {7'd0, i_item.data[0]};
                        end
                    end
                end else if (region == bmsi_pkg::RGN_PRG0) begin
                    o_result.map_valid = 1'b1;
                    o_result.map_slot  = bmsi_pkg::SLOT_PRG0;
                    o_result.map_bank  = {2'b00, i_item.data[5:0]};
                end else if (region == bmsi_pkg::RGN_PRG1) begin
                    o_result.map_valid = 1'b1;
                    o_result.map_slot  = bmsi_pkg::SLOT_PRG1;
                    o_result.map_bank  = {2'b00, i_item.data[5:0]};
                    o_state.lo_sel     = i_item.data[6];
                    o_state.hi_sel     = i_item.data[7];
                end else if (region == bmsi_pkg::RGN_PRG2) begin
                    o_result.map_valid = 1'b1;
                    o_result.map_slot  = bmsi_pkg::SLOT_PRG2;
                    o_result.map_bank  = {2'b00, i_item.data[5:0]};
                end else if (i_item.address == bmsi_pkg::PTR_PORT) begin
                    if (ram_mode) begin
                        o_state.ram_ptr = i_item.data;
                    end else begin
                        o_result.sound_access = 1'b1;
                    end
                end
            end
            bmsi_pkg::ACT_TICK: begin
                if (i_state.irq_on) begin
                    if (tick_sum >= {1'b0, bmsi_pkg::COUNT_TOP}) begin
                        o_state.irq_count  = bmsi_pkg::COUNT_TOP;
                        o_result.irq_pulse = 1'b1;
                    end else begin
                        o_state.irq_count = tick_sum[14:0];
                    end
                end
            end
            default: begin
                // undefined action code: no state change, all-zero result
            end
        endcase
    end

endmodule

`default_nettype wire

[hw/rtl/bank_mapper_scanline_irq.sv]
// Top level of the bank mapper with scanline IRQ counter and side RAM port.
// Depends on bmsi_pkg and bmsi_decode.
//
// Usage:
// - Input channel (i_in_valid / o_in_ready) carries one beat per bus read,
//   bus write or scanline tick: i_action, i_address, i_data.
// - Output channel (o_out_valid / i_out_ready) returns exactly one result
//   beat per input beat, in order: read data, IRQ pulse, bank slot update
//   and the sound-unit access flag.
// - Config channel (i_cfg_valid / o_cfg_ready) writes variant (index 0) or
//   irq_step (index 1). Always ready; write only while the block is idle.
// - Pipeline: input register, then result register; the result is registered.
//   Throughput: one beat per cycle while i_out_ready holds, set by the single
//   decode stage between the two registers and the side RAM's one port.
// - Stall: while the result waits, the input register still takes one beat;
//   both registers then hold and o_in_ready drops until i_out_ready returns.
// - Reset (synchronous, active low): both pipeline stages empty, counter,
//   IRQ enable, RAM selects and pointer zero, variant 0, irq_step 113.
//   The 128-byte side RAM has one valid bit per byte, cleared at reset; an
//   unwritten byte reads as zero, so no clearing pass is needed.
`default_nettype none

module bank_mapper_scanline_irq (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // input beats
    input  wire logic        i_in_valid,
    output logic             o_in_ready,
    input  wire logic [1:0]  i_action,
    input  wire logic [15:0] i_address,
    input  wire logic [7:0]  i_data,
    // result beats
    output logic             o_out_valid,
    input  wire logic        i_out_ready,
    output logic [7:0]       o_read_data,
    output logic             o_irq_pulse,
    output logic             o_map_valid,
    output logic [3:0]       o_map_slot,
    output logic             o_map_is_vram,
    output logic [7:0]       o_map_bank,
    output logic             o_sound_access,
    // configuration writes
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic        i_cfg_index,
    input  wire logic [7:0]  i_cfg_data
);

    // pipeline control
    logic                r_s1_vld;
    bmsi_pkg::t_item     r_s1_item;
    logic                r_out_vld;
    bmsi_pkg::t_result   r_res;
    logic                adv;

    // mapper state and configuration
    bmsi_pkg::t_state    r_state;
    bmsi_pkg::t_variant  r_variant;
    logic [7:0]          r_irq_step;

    // decode outputs
    bmsi_pkg::t_state    n_state;
    bmsi_pkg::t_result   n_res;
    bmsi_pkg::t_ram_ctl  ram_ctl;

    // side RAM with per-byte valid bits
    logic [7:0]                    r_ram [bmsi_pkg::RAM_DEPTH];
    logic [bmsi_pkg::RAM_DEPTH-1:0] r_ram_vld;
    logic [7:0]                    r_ram_q;
    logic                          r_ram_q_vld;
    logic                          r_out_ram;

    // result stage advances when empty or drained this cycle
    assign adv         = !r_out_vld || i_out_ready;
    assign o_in_ready  = !r_s1_vld || adv;
    assign o_cfg_ready = 1'b1;

    bmsi_decode u_decode (
        .i_item     (r_s1_item),
        .i_state    (r_state),
        .i_variant  (r_variant),
        .i_irq_step (r_irq_step),
        .o_state    (n_state),
        .o_result   (n_res),
        .o_ram      (ram_ctl)
    );

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
        end else if (o_in_ready) begin
            r_s1_vld <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_s1_item.action  <= i_action;
            r_s1_item.address <= i_address;
            r_s1_item.data    <= i_data;
        end
    end

    // result register, mapper state commit
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
            r_state   <= '0;
        end else if (adv) begin
            r_out_vld <= r_s1_vld;
            if (r_s1_vld) begin
                r_state <= n_state;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv && r_s1_vld) begin
            r_res     <= n_res;
            r_out_ram <= ram_ctl.rd;
        end
    end

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_variant  <= bmsi_pkg::VAR_NORMAL;
            r_irq_step <= bmsi_pkg::IRQ_STEP_RST;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                bmsi_pkg::CFG_VARIANT:  r_variant  <= bmsi_pkg::t_variant'(i_cfg_data[1:0]);
                bmsi_pkg::CFG_IRQ_STEP: r_irq_step <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // side RAM: one access per beat, read data registered with the result
    always_ff @(posedge i_clk) begin
        if (adv && r_s1_vld) begin
            if (ram_ctl.wr) begin
                r_ram[ram_ctl.idx] <= r_s1_item.data;
            end
            if (ram_ctl.rd) begin
                r_ram_q <= r_ram[ram_ctl.idx];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ram_vld   <= '0;
            r_ram_q_vld <= 1'b0;
        end else if (adv && r_s1_vld) begin
            if (ram_ctl.wr) begin
                r_ram_vld[ram_ctl.idx] <= 1'b1;
            end
            if (ram_ctl.rd) begin
                r_ram_q_vld <= r_ram_vld[ram_ctl.idx];
            end
        end
    end

    // outputs
    assign o_out_valid    = r_out_vld;
    assign o_read_data    = r_out_ram ? (r_ram_q_vld ? r_ram_q : 8'd0) : r_res.read_data;
    assign o_irq_pulse    = r_res.irq_pulse;
    assign o_map_valid    = r_res.map_valid;
    assign o_map_slot     = r_res.map_slot;
    assign o_map_is_vram  = r_res.map_is_vram;
    assign o_map_bank     = r_res.map_bank;
    assign o_sound_access = r_res.sound_access;

endmodule

`default_nettype wire

[hw/rtl/bmsi_checker.sv]
// Port-level checker for bank_mapper_scanline_irq, attached with bind.
// Depends on the top level's port list only.
`default_nettype none

module bmsi_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        o_out_valid,
    input wire logic        i_out_ready,
    input wire logic        o_irq_pulse,
    input wire logic        o_map_valid,
    input wire logic [3:0]  o_map_slot,
    input wire logic        o_map_is_vram,
    input wire logic [7:0]  o_map_bank,
    input wire logic        o_sound_access
);

    // a stalled result beat stays offered
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid)
        else $error("result beat dropped while stalled");

    // no slot update means slot fields are zero
    a_map_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_map_valid |->
            o_map_slot == 4'd0 && o_map_bank == 8'd0 && !o_map_is_vram)
        else $error("slot fields set without slot update");

    // one beat is a tick, a mapping write or a sound access, never two
    a_exclusive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> $countones({o_irq_pulse, o_map_valid, o_sound_access}) <= 1)
        else $error("conflicting result flags");

    // video RAM pages are 0 or 1, on pattern or nametable slots only
    a_vram_page: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_map_is_vram |-> o_map_bank[7:1] == 7'd0 && o_map_slot[3:2] != 2'b11)
        else $error("bad video RAM mapping");

endmodule

bind bank_mapper_scanline_irq bmsi_checker u_bmsi_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .o_out_valid    (o_out_valid),
    .i_out_ready    (i_out_ready),
    .o_irq_pulse    (o_irq_pulse),
    .o_map_valid    (o_map_valid),
    .o_map_slot     (o_map_slot),
    .o_map_is_vram  (o_map_is_vram),
    .o_map_bank     (o_map_bank),
    .o_sound_access (o_sound_access)
);

`default_nettype wire
